// ===== sv/cqr_pkg.sv =====
// ----------------------------------------------------------------------------
// cqr_pkg
// Shared types and codes of the circular queue with readout.
// ----------------------------------------------------------------------------
package cqr_pkg;

    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic [1:0] CMD_ENQ  = 2'd0;
    localparam logic [1:0] CMD_DEQ  = 2'd1;
    localparam logic [1:0] CMD_PEEK = 2'd2;
    localparam logic [1:0] CMD_DISP = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OVF   = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic REG_CAPACITY = 1'b0;

    typedef struct packed {
        logic       enq;
        logic       imm;
        logic [1:0] imm_status;
        logic       start;
        logic       emit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_free;
        logic empty;
        logic full;
        logic walk_last;
    } t_dp_stat;

endpackage

// ===== sv/circular_queue_with_readout.sv =====
// Enqueue, and every overflow or empty request: result registered and valid in the cycle after accept.
// Dequeue and peek: slot index, registered slot read, then result register after accept; a stalled output waits.
// Display: entries are read in turn from the head through the registered read port of the slot memory
// (FETCH, then EMIT state), and a stalled output holds the walk.
// A new request is taken only once the previous one has produced all its results.
// Synchronous reset empties the queue and sets capacity to 16; slots are not cleared.
// ----------------------------------------------------------------------------
// circular_queue_with_readout
// Bounded circular FIFO of signed 32-bit values with an APB capacity register.
// ----------------------------------------------------------------------------
module circular_queue_with_readout import cqr_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [DATA_W-1:0] i_s_tdata,   // [31:0] value
    input  logic [1:0]        i_s_tuser,   // [1:0] cmd
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [DATA_W-1:0] o_m_tdata,   // [31:0] data
    output logic [1:0]        o_m_tuser,   // [1:0] status
    output logic              o_m_tlast,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_ctrl_cmd        cmd;
    t_dp_stat         stat;
    logic             cfg_we;
    logic [CAP_W-1:0] capacity;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
    assign prdata = (paddr[2] == REG_CAPACITY) ? {{(APB_DW-CAP_W){1'b0}}, capacity} : '0;

    cqr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_cmd   (i_s_tuser),
        .i_stat  (stat),
        .o_ready (o_s_tready),
        .o_cmd   (cmd)
    );

    cqr_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_op       (i_s_tuser),
        .i_value    (i_s_tdata),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (pwdata[CAP_W-1:0]),
        .i_m_ready  (i_m_tready),
        .o_stat     (stat),
        .o_capacity (capacity),
        .o_m_valid  (o_m_tvalid),
        .o_m_status (o_m_tuser),
        .o_m_data   (o_m_tdata),
        .o_m_last   (o_m_tlast)
    );

endmodule

// ===== sv/cqr_ctrl.sv =====
// ----------------------------------------------------------------------------
// cqr_ctrl
// Request sequencer: accepts commands and steps the slot readout walk.
// ----------------------------------------------------------------------------
module cqr_ctrl import cqr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_cmd,
    input  t_dp_stat   i_stat,
    output logic       o_ready,
    output t_ctrl_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;
    localparam logic [1:0] S_EMIT  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    assign o_ready = (r_state == S_IDLE) && i_stat.out_free;
    assign accept  = o_ready && i_valid;

    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.imm_status = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_cmd)
                        CMD_ENQ: begin
                            o_cmd.imm = 1'b1;
                            if (i_stat.full) begin
                                o_cmd.imm_status = ST_OVF;
                            end else begin
                                o_cmd.enq = 1'b1;
                            end
                        end
                        default: begin
                            if (i_stat.empty) begin
                                o_cmd.imm        = 1'b1;
                                o_cmd.imm_status = ST_EMPTY;
                            end else begin
                                o_cmd.start = 1'b1;
                                n_state     = S_FETCH;
                            end
                        end
                    endcase
                end
            end
            S_FETCH: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_stat.walk_last ? S_IDLE : S_FETCH;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== sv/cqr_dp.sv =====
// ----------------------------------------------------------------------------
// cqr_dp
// Slot memory, head/tail/count pointers, readout walk and result register.
// ----------------------------------------------------------------------------
module cqr_dp import cqr_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctrl_cmd         i_cmd,
    input  logic [1:0]        i_op,
    input  logic [DATA_W-1:0] i_value,
    input  logic              i_cfg_we,
    input  logic [CAP_W-1:0]  i_cfg_data,
    input  logic              i_m_ready,
    output t_dp_stat          o_stat,
    output logic [CAP_W-1:0]  o_capacity,
    output logic              o_m_valid,
    output logic [1:0]        o_m_status,
    output logic [DATA_W-1:0] o_m_data,
    output logic              o_m_last
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = (CW > CAP_W) ? CW : CAP_W;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    logic [CAP_W-1:0]  r_capacity, n_capacity;
    logic [IW-1:0]     r_head, n_head;
    logic [IW-1:0]     r_tail, n_tail;
    logic [CW-1:0]     r_count, n_count;
    logic [IW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_left, n_left;
    logic              r_pop, n_pop;
    logic              r_out_valid, n_out_valid;
    logic [1:0]        r_out_status;
    logic [DATA_W-1:0] r_out_data;
    logic              r_out_last;

    logic [EW-1:0]     cap_ext;
    logic [CW-1:0]     cap_eff;
    logic              out_free;

    function automatic logic [IW-1:0] adv(input logic [IW-1:0] idx,
                                          input logic [CW-1:0] cap);
        logic [CW-1:0] nxt;
        nxt = CW'(idx) + CW'(1);
        return (nxt >= cap) ? '0 : nxt[IW-1:0];
    endfunction

    assign cap_ext = EW'(r_capacity);

    always_comb begin
        if (cap_ext == '0) begin
            cap_eff = CW'(1);
        end else if (cap_ext > EW'(DEPTH)) begin
            cap_eff = CW'(DEPTH);
        end else begin
            cap_eff = cap_ext[CW-1:0];
        end
    end

    assign out_free         = !r_out_valid || i_m_ready;
    assign o_stat.out_free  = out_free;
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.full      = (r_count >= cap_eff);
    assign o_stat.walk_last = (r_left == CW'(1));

    always_comb begin
        n_capacity  = r_capacity;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_idx       = r_idx;
        n_left      = r_left;
        n_pop       = r_pop;
        n_out_valid = r_out_valid;
        if (i_m_ready) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.imm || i_cmd.emit) begin
            n_out_valid = 1'b1;
        end
        if (i_cmd.enq) begin
            n_tail  = adv(r_tail, cap_eff);
            n_count = r_count + CW'(1);
        end
        if (i_cmd.start) begin
            n_idx  = r_head;
            n_left = (i_op == CMD_DISP) ? r_count : CW'(1);
            n_pop  = (i_op == CMD_DEQ);
        end
        if (i_cmd.emit) begin
            if (r_pop) begin
                n_count = r_count - CW'(1);
                if (r_count == CW'(1)) begin
                    n_head = '0;
                    n_tail = '0;
                end else begin
                    n_head = adv(r_head, cap_eff);
                end
            end
            n_idx  = adv(r_idx, cap_eff);
            n_left = r_left - CW'(1);
        end
        if (i_cfg_we) begin
            n_capacity = i_cfg_data;
            n_head     = '0;
            n_tail     = '0;
            n_count    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= CAP_RESET;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_left      <= '0;
            r_pop       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_capacity  <= n_capacity;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_left      <= n_left;
            r_pop       <= n_pop;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.enq) begin
            r_mem[r_tail] <= i_value;
        end
        r_rd_data <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.imm) begin
            r_out_status <= i_cmd.imm_status;
            r_out_data   <= '0;
            r_out_last   <= 1'b1;
        end else if (i_cmd.emit) begin
            r_out_status <= ST_OK;
            r_out_data   <= r_rd_data;
            r_out_last   <= (r_left == CW'(1));
        end
    end

    assign o_capacity = r_capacity;
    assign o_m_valid  = r_out_valid;
    assign o_m_status = r_out_status;
    assign o_m_data   = r_out_data;
    assign o_m_last   = r_out_last;

endmodule

// ===== sv/cqr_checker.sv =====
// ----------------------------------------------------------------------------
// cqr_checker
// Port-level checks of the circular queue with readout.
// ----------------------------------------------------------------------------
module cqr_checker import cqr_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_m_tvalid,
    input logic              i_m_tready,
    input logic [DATA_W-1:0] i_m_tdata,
    input logic [1:0]        i_m_tuser,
    input logic              i_m_tlast,
    input logic [APB_DW-1:0] i_prdata
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata)
            && $stable(i_m_tuser) && $stable(i_m_tlast))
        else $error("stalled result changed");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && (i_m_tuser != ST_OK) |-> (i_m_tdata == '0))
        else $error("error result carries data");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && (i_m_tuser != ST_OK) |-> i_m_tlast)
        else $error("error result not marked last");

    a_prdata: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_prdata[APB_DW-1:CAP_W] == '0)
        else $error("read data above capacity field");

endmodule

bind circular_queue_with_readout cqr_checker u_cqr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tuser  (o_m_tuser),
    .i_m_tlast  (o_m_tlast),
    .i_prdata   (prdata)
);
